FILE: rtl/core/rtos_priority_scheduler_defines.svh
// Assertion helpers for the scheduler checker.
`ifndef RTOS_PRIORITY_SCHEDULER_DEFINES_SVH
`define RTOS_PRIORITY_SCHEDULER_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define RPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scheduler check failed");

// Consequent must hold in the same cycle as the antecedent.
`define RPS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scheduler check failed");

`endif

FILE: rtl/core/rps_pkg.sv
package rps_pkg;

    localparam int MAX_THREADS = 32;
    localparam int PRIO_W      = 6;
    localparam int TICKS_W     = 32;
    localparam int ADDR_W      = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int IDX_W       = $clog2(MAX_THREADS + 1);
    localparam int OP_W        = 2;
    localparam int IN_DATA_W   = ((PRIO_W + TICKS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((PRIO_W + 1 + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_DELAY = 2'd1,
        OP_START = 2'd2,
        OP_SCHED = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_SCHED
    } t_state;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [TICKS_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } t_ram_req;

    // Highest set bit plus one, zero for an empty mask
    function automatic logic [PRIO_W-1:0] top_priority(input logic [MAX_THREADS-1:0] m);
        logic [PRIO_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAX_THREADS; i++) begin
            if (m[i]) begin
                p = PRIO_W'(i + 1);
            end
        end
        return p;
    endfunction

endpackage

FILE: rtl/core/rps_ram.sv
module rps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/rps_ctrl.sv
module rps_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_vld,
    output logic                        o_in_rdy,
    input  rps_pkg::t_op                i_op,
    input  logic [rps_pkg::PRIO_W-1:0]  i_prio,
    input  logic [rps_pkg::TICKS_W-1:0] i_ticks,
    output logic                        o_out_vld,
    input  logic                        i_out_rdy,
    output logic [rps_pkg::PRIO_W-1:0]  o_next,
    output logic                        o_sw,
    output rps_pkg::t_ram_req           o_ram_req,
    input  logic [rps_pkg::TICKS_W-1:0] i_ram_rdata
);
    import rps_pkg::*;

    t_state                 r_state, n_state;
    logic [MAX_THREADS-1:0] r_ready, n_ready;
    logic [MAX_THREADS-1:0] r_delayed, n_delayed;
    logic [PRIO_W-1:0]      r_cur, n_cur;
    logic                   r_cur_vld, n_cur_vld;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_wb_vld, n_wb_vld;
    logic [ADDR_W-1:0]      r_wb_idx, n_wb_idx;
    logic                   r_out_vld, n_out_vld;
    logic [PRIO_W-1:0]      r_next, n_next;
    logic                   r_sw, n_sw;

    logic                   accept;
    logic                   load_out;
    logic                   walk_done;
    logic [PRIO_W-1:0]      prio_m1;
    logic [PRIO_W-1:0]      cur_m1;
    logic [PRIO_W-1:0]      pick;
    logic                   start_ok;
    logic                   delay_ok;
    logic [TICKS_W-1:0]     dec;

    assign o_in_rdy  = (r_state == ST_IDLE);
    assign accept    = i_in_vld && o_in_rdy;
    assign load_out  = !r_out_vld || i_out_rdy;
    assign walk_done = (r_idx == IDX_W'(MAX_THREADS));
    assign prio_m1   = i_prio - PRIO_W'(1);
    assign cur_m1    = r_cur - PRIO_W'(1);
    assign start_ok  = (i_prio != '0) && (i_prio <= PRIO_W'(MAX_THREADS));
    assign delay_ok  = r_cur_vld && (r_cur != '0) && (r_cur <= PRIO_W'(MAX_THREADS));
    assign pick      = top_priority(r_ready);
    assign dec       = i_ram_rdata - TICKS_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        OP_TICK:  n_state = ST_WALK;
                        OP_DELAY: n_state = ST_SCHED;
                        OP_START: n_state = ST_IDLE;
                        OP_SCHED: n_state = ST_SCHED;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    n_state = ST_SCHED;
                end
            end
            ST_SCHED: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_ready         = r_ready;
        n_delayed       = r_delayed;
        n_cur           = r_cur;
        n_cur_vld       = r_cur_vld;
        n_idx           = r_idx;
        n_wb_vld        = 1'b0;
        n_wb_idx        = r_idx[ADDR_W-1:0];
        n_out_vld       = r_out_vld && !i_out_rdy;
        n_next          = r_next;
        n_sw            = r_sw;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = cur_m1[ADDR_W-1:0];
        o_ram_req.wdata = i_ticks;
        o_ram_req.raddr = r_idx[ADDR_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        OP_START: begin
                            if (start_ok) begin
                                n_ready[prio_m1[ADDR_W-1:0]] = 1'b1;
                            end
                        end
                        OP_DELAY: begin
                            if (delay_ok) begin
                                o_ram_req.we = 1'b1;
                                n_ready[cur_m1[ADDR_W-1:0]]   = 1'b0;
                                n_delayed[cur_m1[ADDR_W-1:0]] = 1'b1;
                            end
                        end
                        OP_TICK:  n_idx = '0;
                        OP_SCHED: n_idx = r_idx;
                        default:  n_idx = r_idx;
                    endcase
                end
            end
            ST_WALK: begin
                // read one entry a cycle, write back the one read last cycle
                if (!walk_done) begin
                    n_idx    = r_idx + IDX_W'(1);
                    n_wb_vld = 1'b1;
                end
                if (r_wb_vld && r_delayed[r_wb_idx]) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = r_wb_idx;
                    o_ram_req.wdata = dec;
                    if (dec == '0) begin
                        n_ready[r_wb_idx]   = 1'b1;
                        n_delayed[r_wb_idx] = 1'b0;
                    end
                end
            end
            ST_SCHED: begin
                if (load_out) begin
                    n_next    = pick;
                    n_sw      = !r_cur_vld || (pick != r_cur);
                    n_cur     = pick;
                    n_cur_vld = 1'b1;
                    n_out_vld = 1'b1;
                end
            end
            default: n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ready   <= '0;
            r_delayed <= '0;
            r_cur     <= '0;
            r_cur_vld <= 1'b0;
            r_idx     <= '0;
            r_wb_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ready   <= n_ready;
            r_delayed <= n_delayed;
            r_cur     <= n_cur;
            r_cur_vld <= n_cur_vld;
            r_idx     <= n_idx;
            r_wb_vld  <= n_wb_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_idx <= n_wb_idx;
        r_next   <= n_next;
        r_sw     <= n_sw;
    end

    assign o_out_vld = r_out_vld;
    assign o_next    = r_next;
    assign o_sw      = r_sw;

endmodule

FILE: rtl/core/rtos_priority_scheduler.sv
// Start: no result; the next transfer is taken in the following cycle.
// Delay and schedule-only: the schedule state registers the result once the output is free.
// Tick: walks the timeout memory one entry a cycle, read then write back, then
// moves to the schedule state, which registers the result.
// Synchronous active-low reset clears masks, current thread and output valid;
// the timeout memory is not cleared, only entries written by a delay are used.
module rtos_priority_scheduler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [5:0] thread_priority, [37:6] delay_ticks, rest zero
    input  logic [rps_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] operation
    input  logic [rps_pkg::OP_W-1:0]       i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [5:0] next_thread, [6] switch_request, [7] zero
    output logic [rps_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import rps_pkg::*;

    t_ram_req           ram_req;
    logic [TICKS_W-1:0] ram_rdata;
    logic [PRIO_W-1:0]  next_thread;
    logic               switch_request;

    rps_ram #(
        .WIDTH (TICKS_W),
        .DEPTH (MAX_THREADS)
    ) u_timeout_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    rps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_vld    (i_s_axis_tvalid),
        .o_in_rdy    (o_s_axis_tready),
        .i_op        (t_op'(i_s_axis_tuser)),
        .i_prio      (i_s_axis_tdata[PRIO_W-1:0]),
        .i_ticks     (i_s_axis_tdata[PRIO_W+TICKS_W-1:PRIO_W]),
        .o_out_vld   (o_m_axis_tvalid),
        .i_out_rdy   (i_m_axis_tready),
        .o_next      (next_thread),
        .o_sw        (switch_request),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    assign o_m_axis_tdata = {(OUT_DATA_W - PRIO_W - 1)'(0), switch_request, next_thread};

endmodule

FILE: rtl/core/rps_checker.sv
`include "rtos_priority_scheduler_defines.svh"

module rps_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           o_s_axis_tready,
    input  logic [rps_pkg::OP_W-1:0]       i_s_axis_tuser,
    input  logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [rps_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import rps_pkg::*;

    logic in_xfer;
    logic out_stall;
    logic start_xfer;
    logic tick_xfer;

    assign in_xfer    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall  = o_m_axis_tvalid && !i_m_axis_tready;
    assign start_xfer = in_xfer && (i_s_axis_tuser == OP_START);
    assign tick_xfer  = in_xfer && (i_s_axis_tuser == OP_TICK);

    // a waiting result holds its value
    `RPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // a start leaves the block open
    `RPS_ASSERT_NEXT(a_start_open, i_clk, i_rst_n, start_xfer, o_s_axis_tready)

    // a tick closes the input while the timeout walk runs
    `RPS_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, tick_xfer, !o_s_axis_tready)

    // no new result may appear in the cycle right after a tick is taken
    `RPS_ASSERT_NEXT(a_tick_no_early, i_clk, i_rst_n, tick_xfer && !o_m_axis_tvalid, !o_m_axis_tvalid)

endmodule

bind rtos_priority_scheduler rps_checker u_rps_checker (.*);
